>>> rtl/core/srpd_pkg.sv
// Shared types and constants for the sensor response packet deframer.
// Holds result codes, frame constants and the result record type.
// No dependencies.
package srpd_pkg;

   // Result codes carried on rsp_result_kind
   localparam logic [2:0] KIND_DATA   = 3'd0;
   localparam logic [2:0] KIND_OK     = 3'd1;
   localparam logic [2:0] KIND_BADHDR = 3'd2;
   localparam logic [2:0] KIND_BADLEN = 3'd3;
   localparam logic [2:0] KIND_BADSUM = 3'd4;

   // Frame constants
   localparam logic [7:0]  HDR_FIRST      = 8'hEF;
   localparam logic [7:0]  HDR_SECOND     = 8'h01;
   localparam logic [31:0] ADDR_RESET     = 32'hFFFF_FFFF;
   localparam int          MAX_PAYLOAD_DEF = 256;
   // Length field counts id-less tail: ack code plus two checksum bytes
   localparam logic [15:0] LEN_OVERHEAD   = 16'd3;

   // One result record
   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] data;
      logic [7:0] id;
      logic [7:0] ack;
      logic [8:0] plen;
      logic       mism;
   } result_type;

endpackage

>>> rtl/core/sensor_response_packet_deframer.sv
// Top level of the sensor response packet deframer.
// Depends on srpd_pkg (codes, constants, result record).
//
// Usage:
//   req_ channel: one received serial byte per transaction (req_rx_byte).
//   rsp_ channel: at most one result per byte: a payload byte, or a frame
//     status (accepted, bad header, bad length, checksum mismatch) with the
//     frame's id, ack code, payload length and address mismatch flag.
//   csr_ port: writes expected_address whenever csr_wr_en is high.
//   An item is taken when valid is high and stall is low.
//   A result is registered when its byte is taken (into skid if rsp_ stalls).
//   Throughput: one byte per cycle while req_stall is low; parser state is
//     updated by a single compare/add step between handshake and result register.
//   A result register plus a one-entry skid register sit on the output, so
//   one more byte is taken while a result waits; req_stall rises only when
//   both hold results, and falls once the receiver takes one.
//   Reset (synchronous, active high) returns the parser to header hunting,
//   drops pending results and sets expected_address to all ones.
module sensor_response_packet_deframer
   import srpd_pkg::*;
#(
   parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // byte input
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   // result output
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_result_kind,
   output logic [7:0]  rsp_payload_byte,
   output logic [7:0]  rsp_packet_id,
   output logic [7:0]  rsp_ack_code,
   output logic [8:0]  rsp_payload_length,
   output logic        rsp_address_mismatch,
   // configuration
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);

   localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);
   localparam logic [16:0] LEN_MAX = 17'(MAX_PAYLOAD) + 17'd3;

   typedef enum logic [3:0] {
      PH_HUNT, PH_HDR1, PH_ADDR0, PH_ADDR1, PH_ADDR2, PH_ADDR3,
      PH_ID, PH_LENH, PH_LENL, PH_ACK, PH_DATA, PH_CKH, PH_CKL
   } phase_type;

   phase_type         phase_ff, phase_in;
   logic [LEN_W-1:0]  decl_len_ff, decl_len_in;
   logic [LEN_W-1:0]  rcv_cnt_ff, rcv_cnt_in;
   logic [15:0]       sum_ff, sum_in;
   logic [7:0]        len_high_ff, len_high_in;
   logic [7:0]        ck_high_ff, ck_high_in;
   logic [7:0]        id_ff, id_in;
   logic [7:0]        ack_ff, ack_in;
   logic [23:0]       addr_ff, addr_in;
   logic              addr_bad_ff, addr_bad_in;
   logic [31:0]       exp_addr_ff;

   logic              req_accept;
   logic              has_result;
   result_type        result;
   result_type        out_ff, skid_ff;
   logic              out_valid_ff, skid_valid_ff;

   logic [15:0]       len_word;
   logic              len_ok;
   logic [LEN_W:0]    rcv_next;
   logic [8:0]        plen9;

   assign req_stall  = skid_valid_ff;
   assign req_accept = req_valid && !skid_valid_ff;

   assign len_word = {len_high_ff, req_rx_byte};
   assign len_ok   = (len_word >= LEN_OVERHEAD) && ({1'b0, len_word} <= LEN_MAX);
   assign rcv_next = {1'b0, rcv_cnt_ff} + {{LEN_W{1'b0}}, 1'b1};
   assign plen9    = 9'(decl_len_ff);

   // Parser step for one byte
   always_comb begin
      phase_in    = phase_ff;
      decl_len_in = decl_len_ff;
      rcv_cnt_in  = rcv_cnt_ff;
      sum_in      = sum_ff;
      len_high_in = len_high_ff;
      ck_high_in  = ck_high_ff;
      id_in       = id_ff;
      ack_in      = ack_ff;
      addr_in     = addr_ff;
      addr_bad_in = addr_bad_ff;
      has_result  = 1'b0;
      result      = '0;
      case (phase_ff)
         PH_HUNT: begin
            if (req_rx_byte == HDR_FIRST) begin
               phase_in = PH_HDR1;
            end
         end
         PH_HDR1: begin
            if (req_rx_byte == HDR_SECOND) begin
               phase_in = PH_ADDR0;
            end else begin
               has_result  = 1'b1;
               result.kind = KIND_BADHDR;
               // a repeated 0xEF may open a fresh header
               phase_in = (req_rx_byte == HDR_FIRST) ? PH_HDR1 : PH_HUNT;
            end
         end
         PH_ADDR0, PH_ADDR1, PH_ADDR2: begin
            addr_in  = {addr_ff[15:0], req_rx_byte};
            phase_in = phase_type'(phase_ff + 4'd1);
         end
         PH_ADDR3: begin
            addr_bad_in = ({addr_ff, req_rx_byte} != exp_addr_ff);
            phase_in    = PH_ID;
         end
         PH_ID: begin
            id_in    = req_rx_byte;
            sum_in   = {8'd0, req_rx_byte};
            phase_in = PH_LENH;
         end
         PH_LENH: begin
            len_high_in = req_rx_byte;
            sum_in      = sum_ff + {8'd0, req_rx_byte};
            phase_in    = PH_LENL;
         end
         PH_LENL: begin
            sum_in = sum_ff + {8'd0, req_rx_byte};
            if (len_ok) begin
               decl_len_in = LEN_W'(len_word - LEN_OVERHEAD);
               phase_in    = PH_ACK;
            end else begin
               has_result  = 1'b1;
               result.kind = KIND_BADLEN;
               result.id   = id_ff;
               result.mism = addr_bad_ff;
               decl_len_in = '0;
               phase_in    = PH_HUNT;
            end
         end
         PH_ACK: begin
            ack_in     = req_rx_byte;
            sum_in     = sum_ff + {8'd0, req_rx_byte};
            rcv_cnt_in = '0;
            phase_in   = (decl_len_ff == '0) ? PH_CKH : PH_DATA;
         end
         PH_DATA: begin
            sum_in     = sum_ff + {8'd0, req_rx_byte};
            rcv_cnt_in = rcv_next[LEN_W-1:0];
            if (rcv_next >= {1'b0, decl_len_ff}) begin
               phase_in = PH_CKH;
            end
            has_result  = 1'b1;
            result.kind = KIND_DATA;
            result.data = req_rx_byte;
            result.id   = id_ff;
            result.ack  = ack_ff;
            result.plen = plen9;
            result.mism = addr_bad_ff;
         end
         PH_CKH: begin
            ck_high_in = req_rx_byte;
            phase_in   = PH_CKL;
         end
         PH_CKL: begin
            has_result  = 1'b1;
            result.kind = ({ck_high_ff, req_rx_byte} == sum_ff) ? KIND_OK : KIND_BADSUM;
            result.id   = id_ff;
            result.ack  = ack_ff;
            result.plen = plen9;
            result.mism = addr_bad_ff;
            phase_in    = PH_HUNT;
         end
         default: begin
            phase_in = PH_HUNT;
         end
      endcase
   end

   // Parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
      end else if (req_accept) begin
         phase_ff <= phase_in;
      end
      if (req_accept) begin
         decl_len_ff <= decl_len_in;
         rcv_cnt_ff  <= rcv_cnt_in;
         sum_ff      <= sum_in;
         len_high_ff <= len_high_in;
         ck_high_ff  <= ck_high_in;
         id_ff       <= id_in;
         ack_ff      <= ack_in;
         addr_ff     <= addr_in;
         addr_bad_ff <= addr_bad_in;
      end
   end

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         exp_addr_ff <= ADDR_RESET;
      end else if (csr_wr_en) begin
         exp_addr_ff <= csr_wr_data;
      end
   end

   // Result register with one-entry skid
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || !rsp_stall) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= req_accept && has_result;
         end
      end else if (req_accept && has_result) begin
         skid_valid_ff <= 1'b1;
      end
      if (!out_valid_ff || !rsp_stall) begin
         out_ff <= skid_valid_ff ? skid_ff : result;
      end else if (req_accept && has_result) begin
         skid_ff <= result;
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_result_kind      = out_ff.kind;
   assign rsp_payload_byte     = out_ff.data;
   assign rsp_packet_id        = out_ff.id;
   assign rsp_ack_code         = out_ff.ack;
   assign rsp_payload_length   = out_ff.plen;
   assign rsp_address_mismatch = out_ff.mism;

   // Skid entry is only used behind a held result
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid holds a result while output register is empty");

   // A result produced while the output is stalled lands in the skid entry
   a_stall_to_skid: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && rsp_stall && req_accept && has_result) |=> skid_valid_ff)
      else $error("result lost while output stalled");

   // Header hunting never produces a result
   a_hunt_silent: assert property (@(posedge clock) disable iff (reset)
      (req_accept && phase_ff == PH_HUNT) |-> !has_result)
      else $error("result produced while hunting for header");

endmodule

>>> tb/srpd_scoreboard_pkg.sv
// Scoreboard for the sensor response packet deframer testbench.
// Holds a byte-level frame predictor, the queue of expected results and the checker.
// Depends on srpd_pkg (result codes, frame constants, result record).
package srpd_scoreboard_pkg;
   import srpd_pkg::*;

   // Parser phase of the predictor
   typedef enum logic [3:0] {
      SEEK, HDR_LOW, ADDR_BYTE, PKT_ID, LEN_HI, LEN_LO, ACK_BYTE, DATA_BYTE, SUM_HI, SUM_LO
   } frame_phase_type;

   class deframe_scoreboard_type;
      logic [31:0]     expected_addr = ADDR_RESET;
      frame_phase_type phase = SEEK;
      int              addr_count;
      logic [31:0]     addr_shift;
      logic            addr_bad;
      logic [7:0]      pkt_id;
      logic [7:0]      ack;
      logic [7:0]      len_hi;
      logic [7:0]      sum_hi;
      logic [8:0]      payload_len;
      int              data_count;
      logic [15:0]     frame_sum;
      result_type      pending_results[$];
      int              failures;

      function void set_address(logic [31:0] value);
         expected_addr = value;
      endfunction

      function int pending();
         return pending_results.size();
      endfunction

      // Clear per-frame state on a header start byte
      function void open_frame();
         phase       = HDR_LOW;
         addr_count  = 0;
         addr_shift  = '0;
         addr_bad    = 1'b0;
         pkt_id      = '0;
         ack         = '0;
         len_hi      = '0;
         sum_hi      = '0;
         payload_len = '0;
         data_count  = 0;
         frame_sum   = '0;
      endfunction

      // Predict the result (if any) caused by one accepted byte
      function void note_rx_byte(logic [7:0] b);
         result_type r;
         bit         has_result;
         int         len;
         r = '0;
         has_result = 0;
         case (phase)
            SEEK: begin
               if (b == HDR_FIRST) open_frame();
            end
            HDR_LOW: begin
               if (b == HDR_SECOND) begin
                  phase = ADDR_BYTE;
               end else begin
                  r.kind = KIND_BADHDR;
                  has_result = 1;
                  // a repeated start byte begins a fresh header
                  if (b == HDR_FIRST) open_frame();
                  else phase = SEEK;
               end
            end
            ADDR_BYTE: begin
               addr_shift = {addr_shift[23:0], b};
               if (addr_count == 3) begin
                  addr_bad = (addr_shift != expected_addr);
                  phase = PKT_ID;
               end else begin
                  addr_count++;
               end
            end
            PKT_ID: begin
               pkt_id = b;
               frame_sum += 16'(b);
               phase = LEN_HI;
            end
            LEN_HI: begin
               len_hi = b;
               frame_sum += 16'(b);
               phase = LEN_LO;
            end
            LEN_LO: begin
               frame_sum += 16'(b);
               len = int'({len_hi, b});
               if (len < 3 || len - 3 > MAX_PAYLOAD_DEF) begin
                  r.kind = KIND_BADLEN;
                  r.id = pkt_id;
                  r.mism = addr_bad;
                  has_result = 1;
                  phase = SEEK;
               end else begin
                  payload_len = 9'(len - 3);
                  phase = ACK_BYTE;
               end
            end
            ACK_BYTE: begin
               ack = b;
               frame_sum += 16'(b);
               phase = (payload_len == 0) ? SUM_HI : DATA_BYTE;
            end
            DATA_BYTE: begin
               frame_sum += 16'(b);
               data_count++;
               if (data_count >= int'(payload_len)) phase = SUM_HI;
               r = '{kind: KIND_DATA, data: b, id: pkt_id, ack: ack, plen: payload_len,
                     mism: addr_bad};
               has_result = 1;
            end
            SUM_HI: begin
               sum_hi = b;
               phase = SUM_LO;
            end
            SUM_LO: begin
               r = '{kind: ({sum_hi, b} == frame_sum) ? KIND_OK : KIND_BADSUM, data: 8'h00,
                     id: pkt_id, ack: ack, plen: payload_len, mism: addr_bad};
               has_result = 1;
               phase = SEEK;
            end
            default: phase = SEEK;
         endcase
         if (has_result) pending_results.push_back(r);
      endfunction

      // Compare one received result with the oldest prediction
      function void check_result(result_type got);
         result_type want;
         if (pending_results.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("unexpected result: kind=%0d data=%02h id=%02h ack=%02h len=%0d mism=%0d",
                        got.kind, got.data, got.id, got.ack, got.plen, got.mism);
            return;
         end
         want = pending_results.pop_front();
         if (got.kind !== want.kind || got.data !== want.data || got.id !== want.id ||
             got.ack !== want.ack || got.plen !== want.plen || got.mism !== want.mism) begin
            failures++;
            if (failures <= 10) begin
               $display("result mismatch at %0t", $time);
               $display("  expected kind=%0d data=%02h id=%02h ack=%02h len=%0d mism=%0d",
                        want.kind, want.data, want.id, want.ack, want.plen, want.mism);
               $display("  actual   kind=%0d data=%02h id=%02h ack=%02h len=%0d mism=%0d",
                        got.kind, got.data, got.id, got.ack, got.plen, got.mism);
            end
         end
      endfunction
   endclass

endpackage

>>> tb/sensor_response_packet_deframer_test.sv
// Top-level testbench for the sensor response packet deframer.
// Drives directed and random response frames with random idling on both sides.
// Depends on srpd_pkg, srpd_scoreboard_pkg and the deframer RTL.
module sensor_response_packet_deframer_test;
   import srpd_pkg::*;
   import srpd_scoreboard_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_rx_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [2:0]  rsp_result_kind;
   logic [7:0]  rsp_payload_byte;
   logic [7:0]  rsp_packet_id;
   logic [7:0]  rsp_ack_code;
   logic [8:0]  rsp_payload_length;
   logic        rsp_address_mismatch;
   logic        csr_wr_en;
   logic [31:0] csr_wr_data;

   deframe_scoreboard_type sb = new;

   bit          tx_idle_on;
   bit          rx_idle_on;
   bit          hold_request;
   int          frame_items;
   logic [31:0] cur_addr;

   sensor_response_packet_deframer i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_rx_byte          (req_rx_byte),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_result_kind      (rsp_result_kind),
      .rsp_payload_byte     (rsp_payload_byte),
      .rsp_packet_id        (rsp_packet_id),
      .rsp_ack_code         (rsp_ack_code),
      .rsp_payload_length   (rsp_payload_length),
      .rsp_address_mismatch (rsp_address_mismatch),
      .csr_wr_en            (csr_wr_en),
      .csr_wr_data          (csr_wr_data)
   );

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run limit
   initial begin
      #5_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Receiver: random stall bursts, plus one long hold-off on request
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 0;
            hold_left = 200;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            hold_left = $urandom_range(0, 16);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result('{kind: rsp_result_kind, data: rsp_payload_byte, id: rsp_packet_id,
                           ack: rsp_ack_code, plen: rsp_payload_length,
                           mism: rsp_address_mismatch});
   end

   // Offer one byte, with an optional idle burst first, and wait for the transaction
   task automatic send_byte(input logic [7:0] value);
      @(negedge clock);
      if (tx_idle_on && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_rx_byte(value);
   endtask

   // Stop offering and wait until every predicted result has come out
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Register write; callers drain pending results first
   task automatic write_address(input logic [31:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      sb.set_address(value);
      cur_addr = value;
   endtask

   // Build and send one frame; an invalid length stops the frame after the length field.
   // split_at >= 0 pauses before that byte to rewrite the address register.
   task automatic send_frame(input logic [31:0] addr, input logic [15:0] len_field,
                             input bit corrupt_sum, input int split_at,
                             input logic [31:0] split_value);
      logic [7:0]  frame_bytes[$];
      logic [15:0] sum;
      logic [7:0]  id;
      logic [7:0]  ack;
      logic [7:0]  b;
      id  = 8'($urandom);
      ack = 8'($urandom);
      frame_bytes = '{HDR_FIRST, HDR_SECOND, addr[31:24], addr[23:16], addr[15:8], addr[7:0],
                      id, len_field[15:8], len_field[7:0]};
      sum = 16'(id) + 16'(len_field[15:8]) + 16'(len_field[7:0]);
      if (len_field >= 3 && int'(len_field) - 3 <= MAX_PAYLOAD_DEF) begin
         frame_bytes.push_back(ack);
         sum += 16'(ack);
         repeat (int'(len_field) - 3) begin
            b = 8'($urandom);
            frame_bytes.push_back(b);
            sum += 16'(b);
         end
         if (corrupt_sum) sum ^= 16'($urandom_range(1, 65535));
         frame_bytes.push_back(sum[15:8]);
         frame_bytes.push_back(sum[7:0]);
      end
      foreach (frame_bytes[i]) begin
         if (i == split_at) begin
            drain_results();
            write_address(split_value);
         end
         send_byte(frame_bytes[i]);
      end
      frame_items += frame_bytes.size();
   endtask

   // Address for a frame: matching half the time, else one bit off or random
   function automatic logic [31:0] pick_addr();
      case ($urandom_range(0, 3))
         0, 1: return cur_addr;
         2: return cur_addr ^ (32'd1 << $urandom_range(0, 31));
         default: return $urandom;
      endcase
   endfunction

   // Valid length field, mostly short payloads
   function automatic logic [15:0] pick_good_length();
      case ($urandom_range(0, 9))
         0: return 16'd3;
         1: return 16'(3 + $urandom_range(13, 64));
         default: return 16'(3 + $urandom_range(1, 12));
      endcase
   endfunction

   // Out-of-range length field
   function automatic logic [15:0] pick_bad_length();
      case ($urandom_range(0, 3))
         0: return 16'($urandom_range(0, 2));
         1: return 16'd260;
         2: return 16'hFFFF;
         default: return 16'($urandom_range(261, 65534));
      endcase
   endfunction

   // Main stimulus
   initial begin
      logic [31:0] phase_addr[5];
      logic [7:0]  b;
      int          target;
      int          sel;
      bit          first;

      reset        = 1'b1;
      req_valid    = 1'b0;
      req_rx_byte  = 8'h00;
      csr_wr_en    = 1'b0;
      csr_wr_data  = 32'h0;
      tx_idle_on   = 1;
      rx_idle_on   = 1;
      hold_request = 0;
      frame_items  = 0;
      cur_addr     = ADDR_RESET;
      phase_addr   = '{32'h0000_0000, 32'hFFFF_FFFF, $urandom, $urandom, 32'hEF01_EF01};
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // Directed: noise extremes, bad header, restart on a repeated start byte,
      // empty payload at the reset address, then a too-short length
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(HDR_FIRST);
      send_byte(8'h02);
      send_byte(HDR_FIRST);
      send_frame(32'hFFFF_FFFF, 16'd3, 0, -1, 32'h0);
      send_frame(32'h0000_0000, 16'd2, 0, -1, 32'h0);

      // Random phases, each under its own address setting
      for (int p = 0; p < 5; p++) begin
         drain_results();
         tx_idle_on = (p < 4);
         rx_idle_on = (p < 4);
         if (p != 2) write_address(phase_addr[p]);
         if (p == 1) hold_request = 1;
         // largest payload once
         if (p == 3) send_frame(pick_addr(), 16'(MAX_PAYLOAD_DEF + 3), 0, -1, 32'h0);
         target = frame_items + 65;
         first = 1;
         while (frame_items < target) begin
            if (first && p == 2) begin
               // register rewritten in the middle of the address field
               send_frame(phase_addr[2], pick_good_length(), 0, 4, phase_addr[2]);
               first = 0;
               continue;
            end
            first = 0;
            sel = $urandom_range(0, 19);
            case (sel)
               0: begin
                  repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
               end
               1: begin
                  b = 8'($urandom);
                  if (b == HDR_SECOND) b = 8'h00;
                  send_byte(HDR_FIRST);
                  send_byte(b);
                  frame_items += 2;
               end
               2: send_frame(pick_addr(), pick_bad_length(), 0, -1, 32'h0);
               3: send_frame(pick_addr(), pick_good_length(), 1, -1, 32'h0);
               default: send_frame(pick_addr(), pick_good_length(), 0, -1, 32'h0);
            endcase
         end
      end

      drain_results();
      repeat (10) @(negedge clock);
      if (sb.failures == 0 && sb.pending() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
